[rtl/adc_frame_ready_poll_decoder_macros.svh]
// assertion macros shared by the decoder rtl
`ifndef ADC_FRAME_READY_POLL_DECODER_MACROS_SVH
`define ADC_FRAME_READY_POLL_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define AFRPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afrpd assertion failed");
// next-cycle implication
`define AFRPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afrpd assertion failed");
`else
`define AFRPD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AFRPD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/afrpd_pkg.sv]
package afrpd_pkg;

  localparam int FRAME_BYTES_DEF = 15;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int NUM_CH          = 3;
  localparam int WORD_BITS       = 24;
  localparam int BYTES_PER_WORD  = 3;
  localparam int STATUS_POS      = 1;
  localparam int DATA_FIRST_POS  = 3;
  localparam int DATA_LAST_POS   = DATA_FIRST_POS + NUM_CH * BYTES_PER_WORD - 1;
  localparam int GAIN_W          = 3;
  localparam int VOLT_W          = 31;
  localparam int RETRY_W         = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 8;
  localparam int FQ_DEPTH        = 2;
  localparam int OQ_DEPTH        = 2;

  localparam logic [RETRY_W-1:0] RETRY_RESET = 8'd100;
  localparam logic [RETRY_W-1:0] POLL_MAX    = 8'hFF;
  localparam logic [GAIN_W-1:0]  GAIN_TOP    = 3'd7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CH0    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CH1    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_CH2    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd3;

  typedef struct packed {
    logic                     done;
    logic [NUM_CH-1:0]        ready;
    logic                     abort;
    logic signed [VOLT_W-1:0] volts0;
    logic signed [VOLT_W-1:0] volts1;
    logic signed [VOLT_W-1:0] volts2;
  } res_t;

  // signed 24-bit word times two to (7 - gain), lsb 2.4 V / 2^31
  function automatic logic signed [VOLT_W-1:0] scale_word(input logic [WORD_BITS-1:0] word,
                                                          input logic [GAIN_W-1:0] gain);
    logic signed [VOLT_W-1:0] ext;
    ext = {{(VOLT_W-WORD_BITS){word[WORD_BITS-1]}}, word};
    return ext <<< (GAIN_TOP - gain);
  endfunction

endpackage

[rtl/afrpd_fifo.sv]
`include "adc_frame_ready_poll_decoder_macros.svh"

module afrpd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `AFRPD_ASSERT_IMP(a_fifo_cnt_range, clk, rst_n, 1'b1, cnt_r <= CNT_W'(DEPTH))
  `AFRPD_ASSERT_NXT(a_fifo_ptr_gap, clk, rst_n, do_push && !do_pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule

[rtl/afrpd_front.sv]
module afrpd_front import afrpd_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_push,
  input  logic [7:0]                              in_rx_byte,
  input  logic                                    in_frame_first,
  input  logic                                    fq_full,
  output logic                                    fq_push,
  output logic [NUM_CH + NUM_CH*SAMPLE_BITS-1:0]  fq_data
);

  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam int FR_W  = NUM_CH + NUM_CH * SAMPLE_BITS;

  logic [POS_W-1:0]     pos_r, pos_nxt, pos;
  logic [NUM_CH-1:0]    status_r, status_nxt;
  logic [WORD_BITS-1:0] shift_r [NUM_CH];
  logic [WORD_BITS-1:0] shift_nxt [NUM_CH];
  logic                 accept, frame_end, in_data;
  logic [1:0]           ch;

  assign accept    = in_push & ~fq_full;
  assign pos       = in_frame_first ? '0 : pos_r;
  assign frame_end = (pos == POS_W'(FRAME_BYTES - 1));
  assign in_data   = pos inside {[POS_W'(DATA_FIRST_POS):POS_W'(DATA_LAST_POS)]};

  // word slot of the current data byte
  always_comb begin
    if (pos < POS_W'(DATA_FIRST_POS + BYTES_PER_WORD)) begin
      ch = 2'd0;
    end else if (pos < POS_W'(DATA_FIRST_POS + 2 * BYTES_PER_WORD)) begin
      ch = 2'd1;
    end else begin
      ch = 2'd2;
    end
  end

  always_comb begin
    status_nxt = status_r;
    pos_nxt    = pos_r;
    for (int c = 0; c < NUM_CH; c++) begin
      shift_nxt[c] = shift_r[c];
    end
    if (accept) begin
      pos_nxt = frame_end ? '0 : pos + 1'b1;
      if (pos == POS_W'(STATUS_POS)) begin
        status_nxt = in_rx_byte[NUM_CH-1:0];
      end
      for (int c = 0; c < NUM_CH; c++) begin
        if (in_data && ch == 2'(c)) begin
          shift_nxt[c] = {shift_r[c][WORD_BITS-9:0], in_rx_byte};
        end
      end
    end
  end

  // frame snapshot includes this cycle's byte
  always_comb begin
    fq_data[FR_W-1 -: NUM_CH] = status_nxt;
    for (int c = 0; c < NUM_CH; c++) begin
      fq_data[c*SAMPLE_BITS +: SAMPLE_BITS] = shift_nxt[c][WORD_BITS-1 -: SAMPLE_BITS];
    end
  end

  assign fq_push = accept & frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      status_r <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        shift_r[c] <= '0;
      end
    end else begin
      pos_r    <= pos_nxt;
      status_r <= status_nxt;
      for (int c = 0; c < NUM_CH; c++) begin
        shift_r[c] <= shift_nxt[c];
      end
    end
  end

endmodule

[rtl/afrpd_back.sv]
`include "adc_frame_ready_poll_decoder_macros.svh"

module afrpd_back import afrpd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]                    cfg_index,
  input  logic [CFG_DATA_W-1:0]                   cfg_data,
  input  logic                                    fq_empty,
  input  logic [NUM_CH + NUM_CH*SAMPLE_BITS-1:0]  fq_data,
  output logic                                    fq_pop,
  input  logic                                    oq_full,
  output logic                                    oq_push,
  output res_t                                    oq_data
);

  localparam int FR_W = NUM_CH + NUM_CH * SAMPLE_BITS;

  logic [GAIN_W-1:0]        gain_r [NUM_CH];
  logic [RETRY_W-1:0]       retry_r;
  logic [RETRY_W-1:0]       poll_r, poll_nxt;
  logic                     abort_r, abort_nxt;
  logic signed [VOLT_W-1:0] volts_r [NUM_CH];
  logic signed [VOLT_W-1:0] volts_nxt [NUM_CH];
  logic [NUM_CH-1:0]        rdy;
  logic [WORD_BITS-1:0]     word [NUM_CH];
  logic                     take, all_ready, over, done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CH; c++) begin
        gain_r[c] <= '0;
      end
      retry_r <= RETRY_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GAIN_CH0:    gain_r[0] <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_CH1:    gain_r[1] <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_CH2:    gain_r[2] <= cfg_data[GAIN_W-1:0];
        CFG_RETRY_LIMIT: retry_r   <= cfg_data[RETRY_W-1:0];
        default:         ;
      endcase
    end
  end

  assign take      = ~fq_empty & ~oq_full;
  assign fq_pop    = take;
  assign oq_push   = take;
  assign rdy       = fq_data[FR_W-1 -: NUM_CH];
  assign all_ready = &rdy;
  assign over      = (poll_r > retry_r);
  assign done      = all_ready | over;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      // short samples sit in the top bits of the word
      word[c] = WORD_BITS'(fq_data[c*SAMPLE_BITS +: SAMPLE_BITS]) << (WORD_BITS - SAMPLE_BITS);
    end
  end

  always_comb begin
    poll_nxt  = poll_r;
    abort_nxt = abort_r;
    for (int c = 0; c < NUM_CH; c++) begin
      volts_nxt[c] = volts_r[c];
    end
    if (take) begin
      if (done) begin
        poll_nxt  = '0;
        abort_nxt = ~all_ready;
        for (int c = 0; c < NUM_CH; c++) begin
          if (rdy[c]) begin
            volts_nxt[c] = scale_word(word[c], gain_r[c]);
          end
        end
      end else if (poll_r != POLL_MAX) begin
        poll_nxt = poll_r + 1'b1;
      end
    end
  end

  always_comb begin
    oq_data.done   = done;
    oq_data.ready  = rdy;
    oq_data.abort  = abort_nxt;
    oq_data.volts0 = volts_nxt[0];
    oq_data.volts1 = volts_nxt[1];
    oq_data.volts2 = volts_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_r  <= '0;
      abort_r <= 1'b1;
      for (int c = 0; c < NUM_CH; c++) begin
        volts_r[c] <= '0;
      end
    end else begin
      poll_r  <= poll_nxt;
      abort_r <= abort_nxt;
      for (int c = 0; c < NUM_CH; c++) begin
        volts_r[c] <= volts_nxt[c];
      end
    end
  end

  `AFRPD_ASSERT_IMP(a_ready_clears_abort, clk, rst_n, take && all_ready, done && !abort_nxt)
  `AFRPD_ASSERT_NXT(a_done_clears_poll, clk, rst_n, take && done, poll_r == '0)
  `AFRPD_ASSERT_NXT(a_poll_keeps_abort, clk, rst_n, take && !done, abort_r == $past(abort_r))

endmodule

[rtl/adc_frame_ready_poll_decoder.sv]
// Decodes the 15-byte response frames of a three-channel delta-sigma adc, one byte per
// transaction on the in_ queue (in_frame_first realigns to byte 0). At the last byte of each
// frame one result goes out: done_res is 1 when all three data-ready bits were set or the poll
// count went past retry_limit, else 0 to ask for another poll; ready channels then load
// sample * 2^(7 - gain) with lsb 2.4 V / 2^31, and poll_abort tells whether polling gave up.
// Every other byte yields no result. Input rate is one byte per clock; in_full rises only
// when the two-entry frame queue is full, which happens when results back up behind a
// stalled out_ side. A result goes through the frame queue, then the result queue, before it
// shows on the out_ ports. Config writes are taken every cycle (cfg_ready is tied high)
// and must only happen while no frame is in flight.

module adc_frame_ready_poll_decoder import afrpd_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // byte input queue
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [7:0]               in_rx_byte,
  input  logic                     in_frame_first,
  // result queue
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic                     out_done_res,
  output logic                     out_ready_ch0,
  output logic                     out_ready_ch1,
  output logic                     out_ready_ch2,
  output logic                     out_poll_abort,
  output logic signed [VOLT_W-1:0] out_volts_ch0,
  output logic signed [VOLT_W-1:0] out_volts_ch1,
  output logic signed [VOLT_W-1:0] out_volts_ch2,
  // register writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int FR_W = NUM_CH + NUM_CH * SAMPLE_BITS;

  // frame queue between the assembler and the poll logic
  logic            fq_push, fq_full, fq_pop, fq_empty;
  logic [FR_W-1:0] fq_wdata, fq_rdata;

  // result queue, parts the poll logic from the consumer
  logic                  oq_push, oq_full;
  res_t                  oq_wdata;
  logic [$bits(res_t)-1:0] oq_rdata;
  res_t                  out_res;

  // front: byte position, status bits and sample shifters
  afrpd_front #(
    .FRAME_BYTES (FRAME_BYTES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_rx_byte     (in_rx_byte),
    .in_frame_first (in_frame_first),
    .fq_full        (fq_full),
    .fq_push        (fq_push),
    .fq_data        (fq_wdata)
  );

  // the front stalls only when the frame queue is full
  assign in_full = fq_full;

  afrpd_fifo #(
    .WIDTH (FR_W),
    .DEPTH (FQ_DEPTH)
  ) u_frame_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  // back: ready check, poll counting, scaling and held voltages
  afrpd_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fq_empty  (fq_empty),
    .fq_data   (fq_rdata),
    .fq_pop    (fq_pop),
    .oq_full   (oq_full),
    .oq_push   (oq_push),
    .oq_data   (oq_wdata)
  );

  afrpd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OQ_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (oq_rdata),
    .empty (out_empty)
  );

  // unpack the oldest waiting result
  assign out_res         = oq_rdata;
  assign out_done_res    = out_res.done;
  assign out_ready_ch0   = out_res.ready[0];
  assign out_ready_ch1   = out_res.ready[1];
  assign out_ready_ch2   = out_res.ready[2];
  assign out_poll_abort  = out_res.abort;
  assign out_volts_ch0   = out_res.volts0;
  assign out_volts_ch1   = out_res.volts1;
  assign out_volts_ch2   = out_res.volts2;

endmodule

[tb/sv/tb_adc_frame_ready_poll_decoder.sv]
module tb_adc_frame_ready_poll_decoder import afrpd_pkg::*;;

  // clock, reset and block ports
  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_push;
  logic                     in_full;
  logic [7:0]               in_rx_byte;
  logic                     in_frame_first;
  logic                     out_empty;
  logic                     out_pop;
  logic                     out_done_res;
  logic                     out_ready_ch0;
  logic                     out_ready_ch1;
  logic                     out_ready_ch2;
  logic                     out_poll_abort;
  logic signed [VOLT_W-1:0] out_volts_ch0;
  logic signed [VOLT_W-1:0] out_volts_ch1;
  logic signed [VOLT_W-1:0] out_volts_ch2;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  // cycles to let pass after the last expected result before touching registers
  localparam int SETTLE_CYCLES = 12;

  adc_frame_ready_poll_decoder dut (.*);

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // frame tracker: mirrors the decoder state, builds the expected result at
  // each frame end and checks the results popped from the block
  // ---------------------------------------------------------------------------
  class frame_tracker;
    logic [GAIN_W-1:0]    gain [NUM_CH];
    logic [RETRY_W-1:0]   retry_lim;
    logic [3:0]           pos;
    logic [7:0]           status_lo;
    logic [WORD_BITS-1:0] word_sr [NUM_CH];
    logic [RETRY_W-1:0]   polls;
    logic [VOLT_W-1:0]    held [NUM_CH];
    logic                 aborted;
    res_t                 pending [$];
    int                   errors;
    int                   checked;
    int                   finished;
    int                   gave_up;
    bit                   polls_pinned;

    function new();
      for (int c = 0; c < NUM_CH; c++) begin
        gain[c]    = '0;
        word_sr[c] = '0;
        held[c]    = '0;
      end
      retry_lim    = RETRY_RESET;
      pos          = '0;
      status_lo    = '0;
      polls        = '0;
      aborted      = 1'b1;
      errors       = 0;
      checked      = 0;
      finished     = 0;
      gave_up      = 0;
      polls_pinned = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GAIN_CH0:    gain[0] = data[GAIN_W-1:0];
        CFG_GAIN_CH1:    gain[1] = data[GAIN_W-1:0];
        CFG_GAIN_CH2:    gain[2] = data[GAIN_W-1:0];
        CFG_RETRY_LIMIT: retry_lim = data[RETRY_W-1:0];
        default: ;
      endcase
    endfunction

    // sign-extend the sample word and scale by 2^(7 - gain)
    function logic [VOLT_W-1:0] to_volts(logic [WORD_BITS-1:0] w, logic [GAIN_W-1:0] g);
      logic [VOLT_W-1:0] x;
      x = {{(VOLT_W-WORD_BITS){w[WORD_BITS-1]}}, w};
      return x << (GAIN_TOP - g);
    endfunction

    function void note_byte(logic [7:0] b, logic first);
      logic [3:0]        p;
      logic [NUM_CH-1:0] rdy;
      logic              fin;
      int                c;
      res_t              e;
      p = first ? 4'd0 : pos;
      if (p == STATUS_POS) begin
        status_lo = b;
      end else if (p >= DATA_FIRST_POS && p <= DATA_LAST_POS) begin
        c = (int'(p) - DATA_FIRST_POS) / BYTES_PER_WORD;
        word_sr[c] = {word_sr[c][WORD_BITS-9:0], b};
      end
      if (int'(p) != FRAME_BYTES_DEF - 1) begin
        pos = p + 4'd1;
        return;
      end
      pos = '0;
      rdy = status_lo[NUM_CH-1:0];
      if (&rdy) begin
        fin     = 1'b1;
        aborted = 1'b0;
      end else if (polls > retry_lim) begin
        fin     = 1'b1;
        aborted = 1'b1;
      end else begin
        fin = 1'b0;
      end
      if (fin) begin
        for (int k = 0; k < NUM_CH; k++)
          if (rdy[k]) held[k] = to_volts(word_sr[k], gain[k]);
        polls = '0;
      end else if (polls != POLL_MAX) begin
        polls = polls + 1'b1;
      end
      if (polls == POLL_MAX) polls_pinned = 1;
      e.done   = fin;
      e.ready  = rdy;
      e.abort  = aborted;
      e.volts0 = held[0];
      e.volts1 = held[1];
      e.volts2 = held[2];
      pending.push_back(e);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task compare_field(string name, logic [VOLT_W-1:0] got, logic [VOLT_W-1:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0h want %0h", checked, name, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        report("result popped with nothing expected");
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.done) finished++;
      if (want.done && want.abort) gave_up++;
      compare_field("done_res",    got.done,     want.done);
      compare_field("ready_ch0",   got.ready[0], want.ready[0]);
      compare_field("ready_ch1",   got.ready[1], want.ready[1]);
      compare_field("ready_ch2",   got.ready[2], want.ready[2]);
      compare_field("poll_abort",  got.abort,    want.abort);
      compare_field("volts_ch0",   got.volts0,   want.volts0);
      compare_field("volts_ch1",   got.volts1,   want.volts1);
      compare_field("volts_ch2",   got.volts2,   want.volts2);
    endtask
  endclass

  frame_tracker book = new();

  // idling control: quiet stretches drop all gaps on both sides
  bit quiet = 0;
  int bytes_sent = 0;

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: pop with random stalls, check on every accepted transaction
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    hold = 0;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_pop = 1'b0;
      end else begin
        out_pop = 1'b1;
        if ($urandom_range(0, 99) < 30) hold = idle_len();
      end
    end
  end

  res_t seen;
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      seen.done   = out_done_res;
      seen.ready  = {out_ready_ch2, out_ready_ch1, out_ready_ch0};
      seen.abort  = out_poll_abort;
      seen.volts0 = out_volts_ch0;
      seen.volts1 = out_volts_ch1;
      seen.volts2 = out_volts_ch2;
      book.check_result(seen);
    end
  end

  // ---------------------------------------------------------------------------
  // byte side
  // ---------------------------------------------------------------------------

  // one byte transaction; push stays high afterwards unless the next call idles
  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_push        = 1'b0;
      in_rx_byte     = 8'($urandom);
      in_frame_first = 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_push        = 1'b1;
    in_rx_byte     = b;
    in_frame_first = first;
    do @(posedge clk); while (in_full);
    book.note_byte(b, first);
    bytes_sent++;
  endtask

  // full frame: header, status word, three sample words, trailing word
  task automatic send_frame(input logic [7:0] status, input logic [23:0] s0,
                            input logic [23:0] s1, input logic [23:0] s2,
                            input logic first);
    logic [7:0] bytes [FRAME_BYTES_DEF];
    for (int i = 0; i < FRAME_BYTES_DEF; i++) bytes[i] = 8'($urandom);
    bytes[STATUS_POS] = status;
    {bytes[3], bytes[4], bytes[5]}    = s0;
    {bytes[6], bytes[7], bytes[8]}    = s1;
    {bytes[9], bytes[10], bytes[11]}  = s2;
    for (int i = 0; i < FRAME_BYTES_DEF; i++) send_byte(bytes[i], (i == 0) ? first : 1'b0);
  endtask

  // sample words lean toward the range ends
  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 24'h800000;
      1:       return 24'h7FFFFF;
      2:       return 24'hFFFFFF;
      3:       return 24'h000000;
      default: return 24'($urandom);
    endcase
  endfunction

  // half the frames have every channel ready, the rest any status at all
  task automatic rand_frame(input logic first);
    logic [7:0] status;
    status = ($urandom_range(0, 1) == 0) ? {5'($urandom), 3'b111} : 8'($urandom);
    send_frame(status, pick_sample(), pick_sample(), pick_sample(), first);
  endtask

  // close a phase: realigned frame, wait for every result, then let the pipe settle
  task automatic finish_phase();
    rand_frame(1'b1);
    @(negedge clk);
    in_push = 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    book.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // gain writes carry random upper bits, which the block must drop
  task automatic apply_setting(input logic [2:0] g0, input logic [2:0] g1,
                               input logic [2:0] g2, input logic [7:0] lim);
    write_reg(CFG_GAIN_CH0, {5'($urandom), g0});
    write_reg(CFG_GAIN_CH1, {5'($urandom), g1});
    write_reg(CFG_GAIN_CH2, {5'($urandom), g2});
    write_reg(CFG_RETRY_LIMIT, lim);
  endtask

  // mostly whole frames, plus cut-off frames and loose bytes with stray realigns
  task automatic random_phase(input int n_items);
    int start;
    int r;
    int len;
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      if ($urandom_range(0, 19) == 0) quiet = !quiet;
      r = $urandom_range(0, 99);
      if (r < 78) begin
        rand_frame(($urandom_range(0, 99) < 85) ? 1'b1 : 1'b0);
      end else if (r < 90) begin
        len = $urandom_range(1, FRAME_BYTES_DEF - 1);
        for (int i = 0; i < len; i++) send_byte(8'($urandom), i == 0);
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
    end
    quiet = 0;
    finish_phase();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_rx_byte     = '0;
    in_frame_first = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset values: nothing ready, fault still set from reset, nothing held
    send_frame(8'h00, 24'h123456, 24'h654321, 24'hABCDEF, 1'b1);
    // all ready with status high bits set, extreme samples, position wraps on its own
    send_frame(8'hFF, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 1'b0);
    // realign in the middle of a frame, then a partial-ready frame
    for (int i = 0; i < 5; i++) send_byte(8'($urandom), i == 0);
    send_frame(8'h05, 24'h000001, 24'h800001, 24'h7FFFFE, 1'b1);
    finish_phase();

    // top gains and zero retry limit: second missed poll already gives up
    apply_setting(3'd7, 3'd7, 3'd7, 8'd0);
    send_frame(8'h07, 24'h800000, 24'h7FFFFF, 24'h000000, 1'b1);
    send_frame(8'h03, 24'h111111, 24'h222222, 24'h333333, 1'b1);
    send_frame(8'h06, 24'h444444, 24'h555555, 24'h666666, 1'b1);
    random_phase(200);

    apply_setting(3'd0, 3'd3, 3'd5, 8'($urandom_range(1, 4)));
    random_phase(200);

    apply_setting(3'($urandom), 3'($urandom), 3'($urandom), 8'($urandom));
    random_phase(200);

    // retry limit at its maximum: a run of missed polls keeps polling
    apply_setting(3'($urandom), 3'($urandom), 3'($urandom), 8'd255);
    quiet = 1;
    for (int n = 0; n < 20; n++)
      send_frame({5'($urandom), 3'($urandom_range(0, 6))}, pick_sample(), pick_sample(),
                 pick_sample(), 1'b1);
    quiet = 0;
    send_frame(8'h07, pick_sample(), pick_sample(), pick_sample(), 1'b1);
    random_phase(100);

    apply_setting(3'($urandom), 3'($urandom), 3'($urandom), 8'd2);
    random_phase(200);

    $display("run covered %0d input bytes and %0d results (%0d finished, %0d gave up)",
             bytes_sent, book.checked, book.finished, book.gave_up);
    $display("poll counter reached its ceiling: %s, mismatches: %0d",
             book.polls_pinned ? "yes" : "no", book.errors);
    if (book.errors == 0)
      $display("adc_frame_ready_poll_decoder regression: pass");
    else
      $display("adc_frame_ready_poll_decoder regression: fail");
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #8_000_000;
    $display("timeout waiting on the decoder");
    $display("adc_frame_ready_poll_decoder regression: fail");
    $finish;
  end

endmodule

[adc_frame_ready_poll_decoder.f]
+incdir+rtl
rtl/afrpd_pkg.sv
rtl/afrpd_fifo.sv
rtl/afrpd_front.sv
rtl/afrpd_back.sv
rtl/adc_frame_ready_poll_decoder.sv
tb/sv/tb_adc_frame_ready_poll_decoder.sv
